/* hw/rtl/hpd_pkg.sv */
`timescale 1ns / 1ps

package hpd_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_CODE_LEN = 16;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int SYM_W  = 8;
  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;
  localparam int BYTE_W = 8;
  localparam int NB_W   = 4;
  // compare width covers both the stored code and the pending code
  localparam int CMP_W  = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
  // common width for length vs pending count
  localparam int LC_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_DATA = 2'd1,
    MODE_END  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SYM = 2'd0,
    KIND_OK  = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_PUSH,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } tbl_wr_t;

endpackage

/* hw/rtl/huffman_prefix_decoder_core.sv */
`timescale 1ns / 1ps

// Table-driven Huffman decoder. Load beats (mode 0) write one slot of the code table. Data
// beats (mode 1) decode the byte held from the previous data beat and keep the new one; an
// end beat (mode 2) decodes the held byte minus its pad bits and then returns one status
// result (ok or error) and clears the stream state, keeping the table. Each decoded bit is
// shifted in and then matched by a linear scan of the code table through its single
// registered read port, cut short at the first matching slot; a found symbol is then staged.
// The output side can stall a beat. One beat is in work at a time; the last result of a
// beat carries last = 1, and the next beat may be accepted while that result still waits
// at the output.
module huffman_prefix_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic [7:0]                 entry_index,
  input  logic [hpd_pkg::SYM_W-1:0]  entry_symbol,
  input  logic [hpd_pkg::CODE_W-1:0] entry_code,
  input  logic [hpd_pkg::LEN_W-1:0]  entry_length,
  input  logic [hpd_pkg::BYTE_W-1:0] data_byte,
  input  logic [2:0]                 pad_bits,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [hpd_pkg::SYM_W-1:0]  symbol,
  output logic                       last
);

  localparam logic [hpd_pkg::IDX_W-1:0] LAST_ADDR = hpd_pkg::IDX_W'(hpd_pkg::TABLE_DEPTH - 1);

  hpd_pkg::state_t state, state_next;

  logic [hpd_pkg::BYTE_W-1:0]       shreg, shreg_next;
  logic [hpd_pkg::NB_W-1:0]         nbits, nbits_next;
  logic                             item_end, item_end_next;
  logic                             status_done, status_done_next;
  logic [hpd_pkg::MAX_CODE_LEN-1:0] pending_code, pending_code_next;
  logic [hpd_pkg::CNT_W-1:0]        pending_count, pending_count_next;
  logic [hpd_pkg::BYTE_W-1:0]       held_byte, held_byte_next;
  logic                             held_valid, held_valid_next;
  logic                             error_seen, error_seen_next;
  logic [hpd_pkg::IDX_W-1:0]        scan_addr, scan_addr_next;
  logic                             issue_done, issue_done_next;
  logic                             look_vld, look_vld_next;
  logic                             look_last, look_last_next;
  hpd_pkg::kind_t                   push_kind, push_kind_next;
  logic [hpd_pkg::SYM_W-1:0]        push_sym, push_sym_next;
  logic                             stg_vld, stg_vld_next;
  hpd_pkg::kind_t                   stg_kind, stg_kind_next;
  logic [hpd_pkg::SYM_W-1:0]        stg_sym, stg_sym_next;
  logic                             out_vld, out_vld_next;
  hpd_pkg::kind_t                   out_kind, out_kind_next;
  logic [hpd_pkg::SYM_W-1:0]        out_sym, out_sym_next;
  logic                             out_last, out_last_next;

  hpd_pkg::tbl_wr_t  tbl_wr;
  hpd_pkg::entry_t   rd_entry;

  logic                      in_fire;
  logic                      out_free;
  logic                      match;
  logic                      scan_miss;
  logic                      bad;
  logic [hpd_pkg::CMP_W-1:0] mask;

  assign in_ready = (state == hpd_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_vld || out_ready;

  assign tbl_wr.en    = in_fire && (mode == hpd_pkg::MODE_LOAD) &&
                        ({1'b0, entry_index} < 9'(hpd_pkg::TABLE_DEPTH));
  assign tbl_wr.addr  = entry_index[hpd_pkg::IDX_W-1:0];
  assign tbl_wr.entry = '{sym: entry_symbol, code: entry_code, len: entry_length};

  hpd_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd_addr  (scan_addr),
    .rd_entry (rd_entry)
  );

  // length equal to a nonzero pending count also rules out zero and overlong slots
  assign mask  = ~({hpd_pkg::CMP_W{1'b1}} << pending_count);
  assign match = (state == hpd_pkg::ST_SCAN) && look_vld &&
                 (hpd_pkg::LC_W'(rd_entry.len) == hpd_pkg::LC_W'(pending_count)) &&
                 ((hpd_pkg::CMP_W'(rd_entry.code) & mask) ==
                  (hpd_pkg::CMP_W'(pending_code) & mask));
  assign scan_miss = look_vld && look_last && !match;
  assign bad       = error_seen || (pending_count != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hpd_pkg::ST_IDLE: begin
        if (in_fire && (mode == hpd_pkg::MODE_DATA || mode == hpd_pkg::MODE_END)) begin
          state_next = hpd_pkg::ST_BIT;
        end
      end
      hpd_pkg::ST_BIT: begin
        priority if (nbits != '0) begin
          if (!error_seen) begin
            state_next = hpd_pkg::ST_SCAN;
          end
        end else if (item_end && !status_done) begin
          state_next = hpd_pkg::ST_PUSH;
        end else begin
          state_next = hpd_pkg::ST_FLUSH;
        end
      end
      hpd_pkg::ST_SCAN: begin
        priority if (match) begin
          state_next = hpd_pkg::ST_PUSH;
        end else if (scan_miss) begin
          state_next = hpd_pkg::ST_BIT;
        end else begin
          state_next = hpd_pkg::ST_SCAN;
        end
      end
      hpd_pkg::ST_PUSH: begin
        if (!stg_vld || out_free) begin
          state_next = hpd_pkg::ST_BIT;
        end
      end
      hpd_pkg::ST_FLUSH: begin
        if (!stg_vld || out_free) begin
          state_next = hpd_pkg::ST_IDLE;
        end
      end
      default: state_next = hpd_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    shreg_next         = shreg;
    nbits_next         = nbits;
    item_end_next      = item_end;
    status_done_next   = status_done;
    pending_code_next  = pending_code;
    pending_count_next = pending_count;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    error_seen_next    = error_seen;
    scan_addr_next     = scan_addr;
    issue_done_next    = issue_done;
    look_vld_next      = look_vld;
    look_last_next     = look_last;
    push_kind_next     = push_kind;
    push_sym_next      = push_sym;
    stg_vld_next       = stg_vld;
    stg_kind_next      = stg_kind;
    stg_sym_next       = stg_sym;
    out_vld_next       = out_vld && !out_ready;
    out_kind_next      = out_kind;
    out_sym_next       = out_sym;
    out_last_next      = out_last;

    unique case (state)
      hpd_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (mode == hpd_pkg::MODE_DATA) begin
            shreg_next      = held_byte;
            nbits_next      = held_valid ? hpd_pkg::NB_W'(8) : '0;
            item_end_next   = 1'b0;
            held_byte_next  = data_byte;
            held_valid_next = 1'b1;
          end else if (mode == hpd_pkg::MODE_END) begin
            shreg_next       = held_byte;
            nbits_next       = held_valid ? hpd_pkg::NB_W'(8) - hpd_pkg::NB_W'(pad_bits) : '0;
            item_end_next    = 1'b1;
            status_done_next = 1'b0;
          end
        end
      end
      hpd_pkg::ST_BIT: begin
        if (nbits != '0) begin
          shreg_next = shreg << 1;
          nbits_next = nbits - 1'b1;
          // after an overlong code the rest of the stream is dropped
          if (!error_seen) begin
            pending_code_next  = (pending_code << 1) |
                                 hpd_pkg::MAX_CODE_LEN'(shreg[hpd_pkg::BYTE_W-1]);
            pending_count_next = pending_count + 1'b1;
            scan_addr_next     = '0;
            issue_done_next    = 1'b0;
            look_vld_next      = 1'b0;
            look_last_next     = 1'b0;
          end
        end else if (item_end && !status_done) begin
          push_kind_next     = bad ? hpd_pkg::KIND_ERR : hpd_pkg::KIND_OK;
          push_sym_next      = '0;
          status_done_next   = 1'b1;
          pending_code_next  = '0;
          pending_count_next = '0;
          held_byte_next     = '0;
          held_valid_next    = 1'b0;
          error_seen_next    = 1'b0;
        end
      end
      hpd_pkg::ST_SCAN: begin
        // read of scan_addr returns next cycle, compared against look_* then
        look_vld_next  = !issue_done;
        look_last_next = (scan_addr == LAST_ADDR);
        if (!issue_done) begin
          if (scan_addr == LAST_ADDR) begin
            issue_done_next = 1'b1;
          end else begin
            scan_addr_next = scan_addr + 1'b1;
          end
        end
        if (match) begin
          push_kind_next     = hpd_pkg::KIND_SYM;
          push_sym_next      = rd_entry.sym;
          pending_code_next  = '0;
          pending_count_next = '0;
        end else if (scan_miss) begin
          if (hpd_pkg::LC_W'(pending_count) >= hpd_pkg::LC_W'(hpd_pkg::MAX_CODE_LEN)) begin
            error_seen_next = 1'b1;
          end
        end
      end
      hpd_pkg::ST_PUSH: begin
        // one result stays staged so the final one can be marked last
        if (!stg_vld || out_free) begin
          if (stg_vld) begin
            out_vld_next  = 1'b1;
            out_kind_next = stg_kind;
            out_sym_next  = stg_sym;
            out_last_next = 1'b0;
          end
          stg_vld_next  = 1'b1;
          stg_kind_next = push_kind;
          stg_sym_next  = push_sym;
        end
      end
      hpd_pkg::ST_FLUSH: begin
        if (stg_vld && out_free) begin
          out_vld_next  = 1'b1;
          out_kind_next = stg_kind;
          out_sym_next  = stg_sym;
          out_last_next = 1'b1;
          stg_vld_next  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= hpd_pkg::ST_IDLE;
      pending_code  <= '0;
      pending_count <= '0;
      held_byte     <= '0;
      held_valid    <= 1'b0;
      error_seen    <= 1'b0;
      item_end      <= 1'b0;
      status_done   <= 1'b0;
      issue_done    <= 1'b0;
      look_vld      <= 1'b0;
      look_last     <= 1'b0;
      stg_vld       <= 1'b0;
      out_vld       <= 1'b0;
    end else begin
      state         <= state_next;
      pending_code  <= pending_code_next;
      pending_count <= pending_count_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      error_seen    <= error_seen_next;
      item_end      <= item_end_next;
      status_done   <= status_done_next;
      issue_done    <= issue_done_next;
      look_vld      <= look_vld_next;
      look_last     <= look_last_next;
      stg_vld       <= stg_vld_next;
      out_vld       <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg     <= shreg_next;
    nbits     <= nbits_next;
    scan_addr <= scan_addr_next;
    push_kind <= push_kind_next;
    push_sym  <= push_sym_next;
    stg_kind  <= stg_kind_next;
    stg_sym   <= stg_sym_next;
    out_kind  <= out_kind_next;
    out_sym   <= out_sym_next;
    out_last  <= out_last_next;
  end

  assign out_valid = out_vld;
  assign kind      = out_kind;
  assign symbol    = out_sym;
  assign last      = out_last;

  a_scan_has_bits: assert property (@(posedge clk) disable iff (rst)
    (state == hpd_pkg::ST_SCAN) |-> (pending_count != '0))
    else $error("table scan with no pending bits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hpd_pkg::LC_W'(pending_count) <= hpd_pkg::LC_W'(hpd_pkg::MAX_CODE_LEN))
    else $error("pending count beyond max code length");

  a_no_match_after_error: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> !match)
    else $error("symbol matched after overlong code");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_kind != hpd_pkg::KIND_SYM) |-> out_last)
    else $error("status result not marked last");

  a_idle_nothing_staged: assert property (@(posedge clk) disable iff (rst)
    (state == hpd_pkg::ST_IDLE) |-> !stg_vld)
    else $error("result left staged while idle");

endmodule

/* hw/rtl/hpd_table.sv */
`timescale 1ns / 1ps

module hpd_table (
  input  logic                     clk,
  input  logic                     rst,
  input  hpd_pkg::tbl_wr_t         wr,
  input  logic [hpd_pkg::IDX_W-1:0] rd_addr,
  output hpd_pkg::entry_t          rd_entry
);

  hpd_pkg::entry_t                   mem [hpd_pkg::TABLE_DEPTH];
  logic [hpd_pkg::TABLE_DEPTH-1:0]   vld;
  hpd_pkg::entry_t                   rd_data;
  logic                              rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_data <= mem[rd_addr];
  end

  // per-slot valid bits stand in for clearing the whole table at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // a never-written slot reads as length zero, which never matches
  always_comb begin
    rd_entry = rd_data;
    if (!rd_vld) begin
      rd_entry = '0;
    end
  end

endmodule
